### src/cgsq_pkg.sv
// Package for the cyclic GF(2) polynomial squaring block.
// Holds widths, command codes and the sequencer state type. No dependencies.
`default_nettype none
package cgsq_pkg;
   localparam int unsigned POLY_DEGREE_DEF = 12323;
   localparam int unsigned NUM_WORDS_DEF   = 193;
   localparam int unsigned WORD_W  = 64;
   localparam int unsigned OP_W    = 2;
   localparam int unsigned INDEX_W = 8;
   localparam int unsigned COUNT_W = 16;

   localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
   localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_RDWAIT, ST_POW, ST_CLR, ST_BRD, ST_BWR, ST_CPR, ST_CPW
   } state_type;
endpackage
`default_nettype wire

### src/cgsq_if.sv
// Request and response channel interfaces for the squaring block.
// Depends on cgsq_pkg for the field widths.
`default_nettype none
interface cgsq_req_if import cgsq_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [INDEX_W-1:0] word_index;
   logic [WORD_W-1:0]  word_data;
   logic [COUNT_W-1:0] square_count;
   modport source (output valid, op, word_index, word_data, square_count, input ready);
   modport sink   (input valid, op, word_index, word_data, square_count, output ready);
endinterface

interface cgsq_rsp_if import cgsq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] read_data;
   logic              done_res;
   modport source (output valid, read_data, done_res, input ready);
   modport sink   (input valid, read_data, done_res, output ready);
endinterface
`default_nettype wire

### src/cgsq_ram.sv
// Single write port, single registered read port word memory.
// Depends on cgsq_pkg for the word width.
`default_nettype none
module cgsq_ram import cgsq_pkg::*; #(
   parameter int unsigned DEPTH = NUM_WORDS_DEF,
   parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [WORD_W-1:0] wr_data,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [WORD_W-1:0] rd_data_ff
);
   logic [WORD_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### src/cyclic_gf2_poly_square_k.sv
// Top level of the cyclic GF(2) squaring engine: sequencer, shared
// modular step unit and two word memories. Depends on cgsq_pkg, cgsq_if, cgsq_ram.
//
//  channel  | direction | contents
//  req_ch   | in        | op, word_index, word_data, square_count
//  rsp_ch   | out       | read_data, done_res
//
// Write and unused op answer one cycle after the request, read after two.
// A run forms 2^k mod R by modular doubling in ST_POW, clears scratch in ST_CLR,
// walks the bits in ST_BRD and ST_BWR (one memory read then one write per bit) and
// copies scratch back to the polynomial memory in ST_CPR and ST_CPW.
// Reset clears only the sequencer state and the response valid flag.
// The request side is not ready while a command runs or a response waits unaccepted.
`default_nettype none
module cyclic_gf2_poly_square_k import cgsq_pkg::*; #(
   parameter int unsigned POLY_DEGREE = POLY_DEGREE_DEF,
   parameter int unsigned NUM_WORDS   = NUM_WORDS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   cgsq_req_if.sink   req_ch,
   cgsq_rsp_if.source rsp_ch
);
   localparam int unsigned AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int unsigned CW = $clog2(POLY_DEGREE) + 1;
   localparam logic [31:0] CAP = 32'(NUM_WORDS * 64);
   localparam logic [CW:0] RMOD = (CW+1)'(POLY_DEGREE);
   localparam logic [AW-1:0] LAST_WORD = AW'(NUM_WORDS - 1);

   state_type state_ff, state_in;
   logic [CW-1:0]      m_ff, m_in, pos_ff, pos_in, bit_ff, bit_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in, done_ff, done_in, oob_ff, oob_in;
   logic [WORD_W-1:0]  rdata_ff, rdata_in;

   logic              p_we, s_we;
   logic [AW-1:0]     p_wa, p_ra, s_wa, s_ra;
   logic [WORD_W-1:0] p_wd, s_wd, p_rd, s_rd;

   logic        accept;
   logic [31:0] req_idx32, lo32, rem32, bit32, pos32;
   logic [WORD_W-1:0] keep;
   logic [CW:0] dbl, sum;
   logic        in_range;

   cgsq_ram #(.DEPTH(NUM_WORDS), .AW(AW)) u_poly (
      .clock(clock), .wr_en(p_we), .wr_addr(p_wa), .wr_data(p_wd),
      .rd_addr(p_ra), .rd_data_ff(p_rd));
   cgsq_ram #(.DEPTH(NUM_WORDS), .AW(AW)) u_scratch (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(s_ra), .rd_data_ff(s_rd));

   assign req_ch.ready     = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept           = req_ch.valid && req_ch.ready;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.read_data = rdata_ff;
   assign rsp_ch.done_res  = done_ff;

   // Shared step unit: modular doubling of m and modular advance of pos.
   assign dbl = {m_ff, 1'b0};
   assign sum = {1'b0, pos_ff} + {1'b0, m_ff};

   always_comb begin
      req_idx32 = 32'(req_ch.word_index);
      lo32      = req_idx32 << 6;
      rem32     = 32'(POLY_DEGREE) - lo32;
      if (lo32 >= 32'(POLY_DEGREE)) begin
         keep = '0;
      end else if (rem32 >= 32'd64) begin
         keep = '1;
      end else begin
         keep = (64'd1 << rem32[5:0]) - 64'd1;
      end
      bit32    = 32'(bit_ff);
      pos32    = 32'(pos_ff);
      in_range = (bit32 < CAP) && (pos32 < CAP);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_ch.op == OP_READ) begin
               state_in = ST_RDWAIT;
            end else if (accept && req_ch.op == OP_RUN) begin
               state_in = ST_POW;
            end
         end
         ST_RDWAIT: state_in = ST_IDLE;
         ST_POW:    if (cnt_ff == '0) state_in = ST_CLR;
         ST_CLR:    if (idx_ff == LAST_WORD) state_in = ST_BRD;
         ST_BRD:    state_in = ST_BWR;
         ST_BWR:    state_in = (bit32 == 32'(POLY_DEGREE - 1)) ? ST_CPR : ST_BRD;
         ST_CPR:    state_in = ST_CPW;
         ST_CPW:    state_in = (idx_ff == LAST_WORD) ? ST_IDLE : ST_CPR;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath and memory controls.
   always_comb begin
      m_in = m_ff; pos_in = pos_ff; bit_in = bit_ff; cnt_in = cnt_ff; idx_in = idx_ff;
      oob_in = oob_ff; rdata_in = rdata_ff; done_in = done_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      p_we = 1'b0; p_wa = idx_ff; p_wd = s_rd;
      s_we = 1'b0; s_wa = idx_ff; s_wd = '0;
      p_ra = req_idx32[AW-1:0];
      s_ra = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rdata_in = '0;
               oob_in   = req_idx32 >= 32'(NUM_WORDS);
               m_in     = CW'(1);
               cnt_in   = req_ch.square_count;
               idx_in   = '0;
               unique case (req_ch.op)
                  OP_WRITE: begin
                     p_we = req_idx32 < 32'(NUM_WORDS);
                     p_wa = req_idx32[AW-1:0];
                     p_wd = req_ch.word_data & keep;
                     rsp_valid_in = 1'b1; done_in = 1'b1;
                  end
                  OP_RUN, OP_READ: ;
                  default: begin
                     rsp_valid_in = 1'b1; done_in = 1'b0;
                  end
               endcase
            end
         end
         ST_RDWAIT: begin
            rsp_valid_in = 1'b1; done_in = 1'b1;
            rdata_in = oob_ff ? '0 : p_rd;
         end
         ST_POW: begin
            if (cnt_ff != '0) begin
               m_in   = (dbl >= RMOD) ? CW'(dbl - RMOD) : CW'(dbl);
               cnt_in = cnt_ff - COUNT_W'(1);
            end
            pos_in = '0; bit_in = '0;
         end
         ST_CLR: begin
            s_we   = 1'b1;
            idx_in = idx_ff + AW'(1);
            if (idx_ff == LAST_WORD) idx_in = '0;
         end
         ST_BRD: begin
            p_ra = AW'(bit32 >> 6);
            s_ra = AW'(pos32 >> 6);
         end
         ST_BWR: begin
            s_we   = in_range;
            s_wa   = AW'(pos32 >> 6);
            s_wd   = s_rd ^ (64'(p_rd[bit32[5:0]]) << pos32[5:0]);
            bit_in = bit_ff + CW'(1);
            pos_in = (sum >= RMOD) ? CW'(sum - RMOD) : CW'(sum);
            idx_in = '0;
         end
         ST_CPR: s_ra = idx_ff;
         ST_CPW: begin
            p_we   = 1'b1;
            idx_in = idx_ff + AW'(1);
            if (idx_ff == LAST_WORD) begin
               rsp_valid_in = 1'b1; done_in = 1'b1; rdata_in = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      m_ff <= m_in; pos_ff <= pos_in; bit_ff <= bit_in; cnt_ff <= cnt_in;
      idx_ff <= idx_in; oob_ff <= oob_in; rdata_ff <= rdata_in; done_ff <= done_in;
   end

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ch.ready) else $error("ready while busy");
   a_m_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BWR) |-> ({1'b0, m_ff} < RMOD)) else $error("multiplier not reduced");
   a_pos_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BWR) |-> ({1'b0, pos_ff} < RMOD)) else $error("position not reduced");
   a_run_ends_in_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CPW && idx_ff == LAST_WORD) |=> (rsp_valid_ff && done_ff))
      else $error("run finished without response");
endmodule
`default_nettype wire
